// ===== design/priority_aging_scheduler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the priority aging scheduler
// Concurrent checks that become empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_AGING_SCHEDULER_UNIT_ASSERT_SVH
`define PRIORITY_AGING_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// condition holds at every edge outside reset
`define PASU_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// consequent holds at the edge after the antecedent
`define PASU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PASU_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define PASU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== design/pasu_pkg.sv =====
// ----------------------------------------------------------------------------
// pasu_pkg
// Shared codes, types and constants of the priority aging scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pasu_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic signed [5:0] PRIO_MAX = 6'sd20;
   localparam logic signed [5:0] PRIO_MIN = -6'sd20;

   // func codes on the request channel
   localparam logic [2:0] FN_SET   = 3'd0;
   localparam logic [2:0] FN_ADD   = 3'd1;
   localparam logic [2:0] FN_REM   = 3'd2;
   localparam logic [2:0] FN_SCHED = 3'd3;
   localparam logic [2:0] FN_READ  = 3'd4;

   // status codes on the response channel
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_PRIO  = 3'd1;
   localparam logic [2:0] ST_ALREADY   = 3'd2;
   localparam logic [2:0] ST_NOT_READY = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   typedef enum logic [2:0] {
      OP_SET,
      OP_ADD,
      OP_REM,
      OP_SCHED,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [3:0]        echo;
      logic signed [5:0] prio;
      logic              prio_bad;
   } item_type;

   typedef struct packed {
      logic [2:0]        status;
      logic signed [5:0] priority_out;
      logic              chosen_valid;
      logic [3:0]        chosen_slot;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/pasu_front.sv =====
// ----------------------------------------------------------------------------
// pasu_front
// Decodes request items, folds the slot number and queues them (2 deep).
// ----------------------------------------------------------------------------
`default_nettype none

module pasu_front import pasu_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int SW    = $clog2(SLOTS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       q_valid,
   output item_type                   q_item,
   output logic [SW-1:0]              q_slot,
   input  wire logic                  q_pop
);

   item_type          item_ent_ff [2];
   logic [SW-1:0]     slot_ent_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;

   item_type          dec_item;
   logic [SW-1:0]     dec_slot;
   logic [2:0]        func;
   logic [3:0]        echo;
   logic signed [5:0] prio;
   logic [8:0]        fold;
   logic              push;

   assign func = req_tdata[2:0];
   assign echo = req_tdata[6:3];
   assign prio = req_tdata[12:7];

   always_comb begin
      dec_item.echo     = echo;
      dec_item.prio     = prio;
      dec_item.prio_bad = (prio > PRIO_MAX) || (prio < PRIO_MIN);
      case (func)
         FN_SET:   dec_item.op = OP_SET;
         FN_ADD:   dec_item.op = OP_ADD;
         FN_REM:   dec_item.op = OP_REM;
         FN_SCHED: dec_item.op = OP_SCHED;
         FN_READ:  dec_item.op = OP_READ;
         default:  dec_item.op = OP_NOP;
      endcase
      // slot number modulo SLOTS; at most 8 subtractions for a 4-bit value
      fold = 9'(echo);
      for (int k = 0; k < 8; k++) begin
         if (fold >= 9'(SLOTS)) begin
            fold = fold - 9'(SLOTS);
         end
      end
      dec_slot = fold[SW-1:0];
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = item_ent_ff[rd_ptr_ff];
   assign q_slot     = slot_ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ent_ff[wr_ptr_ff] <= dec_item;
         slot_ent_ff[wr_ptr_ff] <= dec_slot;
      end
   end

endmodule

`default_nettype wire

// ===== design/pasu_back.sv =====
// ----------------------------------------------------------------------------
// pasu_back
// Executes queued items against the ready list and priority memories.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_aging_scheduler_unit_assert.svh"

module pasu_back import pasu_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   parameter int SW    = $clog2(SLOTS),
   parameter int CW    = $clog2(SLOTS + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          use_priority,
   input  wire logic          q_valid,
   input  wire item_type      q_item,
   input  wire logic [SW-1:0] q_slot,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output rsp_type            rsp_data
);

   localparam int SWX = SW + 4;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_BASE, S_RR_A, S_RR_B, S_RR_C, S_READ, S_DONE
   } state_type;

   function automatic logic [SW-1:0] pos(input logic [SW-1:0] h, input logic [CW-1:0] i);
      logic [CW:0] s;
      s = (CW+1)'(h) + (CW+1)'(i);
      if (s >= (CW+1)'(SLOTS)) begin
         s = s - (CW+1)'(SLOTS);
      end
      return s[SW-1:0];
   endfunction

   function automatic logic [3:0] to4(input logic [SW-1:0] s);
      logic [SWX-1:0] e;
      e = SWX'(s);
      return e[3:0];
   endfunction

   state_type         state_ff, state_in;
   item_type          item_ff, item_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [SW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [SLOTS-1:0]  ready_ff, ready_in;
   logic [SLOTS-1:0]  cur_vld_ff, cur_vld_in;
   logic [SLOTS-1:0]  base_vld_ff, base_vld_in;
   logic [CW-1:0]     iss_ff, iss_in;
   logic              a_vld_ff, a_vld_in;
   logic [CW-1:0]     a_idx_ff, a_idx_in;
   logic              b_vld_ff, b_vld_in;
   logic [SW-1:0]     b_slot_ff, b_slot_in;
   logic              found_ff, found_in;
   logic              best_vld_ff, best_vld_in;
   logic [SW-1:0]     best_ff, best_in;
   logic signed [5:0] best_prio_ff, best_prio_in;
   rsp_type           res_ff, res_in;
   logic              out_vld_ff, out_vld_in;
   rsp_type           out_ff, out_in;

   // memories
   logic [SW-1:0]     order_mem [SLOTS];
   logic [SW-1:0]     order_rd_ff;
   logic signed [5:0] cur_mem [SLOTS];
   logic signed [5:0] cur_rd_ff;
   logic              cur_rvld_ff;
   logic signed [5:0] base_mem [SLOTS];
   logic signed [5:0] base_rd_ff;
   logic              base_rvld_ff;

   logic              ord_we, ord_re;
   logic [SW-1:0]     ord_waddr, ord_wdata, ord_raddr;
   logic              cur_we, cur_re;
   logic [SW-1:0]     cur_waddr, cur_raddr;
   logic signed [5:0] cur_wdata;
   logic              base_we, base_re;
   logic [SW-1:0]     base_raddr;

   logic signed [5:0] cur_val, base_val;
   logic [CW-1:0]     prev_idx;
   logic              scan_done;

   assign cur_val   = cur_rvld_ff  ? cur_rd_ff  : 6'sd0;
   assign base_val  = base_rvld_ff ? base_rd_ff : 6'sd0;
   assign prev_idx  = a_idx_ff - CW'(1);
   assign scan_done = (iss_ff == count_ff) && !a_vld_ff && !b_vld_ff;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_data   = out_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      slot_in      = slot_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      ready_in     = ready_ff;
      cur_vld_in   = cur_vld_ff;
      base_vld_in  = base_vld_ff;
      iss_in       = iss_ff;
      a_vld_in     = 1'b0;
      a_idx_in     = a_idx_ff;
      b_vld_in     = 1'b0;
      b_slot_in    = b_slot_ff;
      found_in     = found_ff;
      best_vld_in  = best_vld_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      res_in       = res_ff;
      out_vld_in   = out_vld_ff && !rsp_tready;
      out_in       = out_ff;
      q_pop        = 1'b0;
      ord_we       = 1'b0;
      ord_waddr    = '0;
      ord_wdata    = '0;
      ord_re       = 1'b0;
      ord_raddr    = '0;
      cur_we       = 1'b0;
      cur_waddr    = '0;
      cur_wdata    = '0;
      cur_re       = 1'b0;
      cur_raddr    = '0;
      base_we      = 1'b0;
      base_re      = 1'b0;
      base_raddr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop                = 1'b1;
               item_in              = q_item;
               slot_in              = q_slot;
               res_in.chosen_slot   = q_item.echo;
               res_in.chosen_valid  = 1'b0;
               res_in.priority_out  = 6'sd0;
               res_in.status        = ST_OK;
               iss_in               = '0;
               found_in             = 1'b0;
               best_vld_in          = 1'b0;
               state_in             = S_DONE;
               case (q_item.op)
                  OP_SET: begin
                     if (q_item.prio_bad) begin
                        res_in.status = ST_BAD_PRIO;
                     end else begin
                        cur_we              = 1'b1;
                        cur_waddr           = q_slot;
                        cur_wdata           = q_item.prio;
                        base_we             = 1'b1;
                        cur_vld_in[q_slot]  = 1'b1;
                        base_vld_in[q_slot] = 1'b1;
                     end
                  end
                  OP_ADD: begin
                     if (ready_ff[q_slot] || count_ff == CW'(SLOTS)) begin
                        res_in.status = ST_ALREADY;
                     end else begin
                        ord_we           = 1'b1;
                        ord_waddr        = pos(head_ff, count_ff);
                        ord_wdata        = q_slot;
                        count_in         = count_ff + CW'(1);
                        ready_in[q_slot] = 1'b1;
                     end
                  end
                  OP_REM: begin
                     if (!ready_ff[q_slot]) begin
                        res_in.status = ST_NOT_READY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_SCHED: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_EMPTY;
                     end else if (!use_priority) begin
                        ord_re    = 1'b1;
                        ord_raddr = head_ff;
                        state_in  = S_RR_A;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_READ: begin
                     cur_re    = 1'b1;
                     cur_raddr = q_slot;
                     state_in  = S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // list walk in order: order read, then (schedule) priority read-age-write
         S_SCAN: begin
            if (iss_ff < count_ff) begin
               ord_re    = 1'b1;
               ord_raddr = pos(head_ff, iss_ff);
               a_vld_in  = 1'b1;
               a_idx_in  = iss_ff;
               iss_in    = iss_ff + CW'(1);
            end
            if (a_vld_ff) begin
               if (item_ff.op == OP_REM) begin
                  if (order_rd_ff == slot_ff) begin
                     found_in = 1'b1;
                  end else if (found_ff) begin
                     ord_we    = 1'b1;
                     ord_waddr = pos(head_ff, prev_idx);
                     ord_wdata = order_rd_ff;
                  end
               end else begin
                  cur_re    = 1'b1;
                  cur_raddr = order_rd_ff;
                  b_vld_in  = 1'b1;
                  b_slot_in = order_rd_ff;
               end
            end
            if (b_vld_ff) begin
               if (!best_vld_ff || cur_val < best_prio_ff) begin
                  best_vld_in  = 1'b1;
                  best_in      = b_slot_ff;
                  best_prio_in = cur_val;
               end
               // age everyone; the chosen one is overwritten with its base later
               cur_we                = 1'b1;
               cur_waddr             = b_slot_ff;
               cur_wdata             = (cur_val > PRIO_MIN) ? cur_val - 6'sd1 : cur_val;
               cur_vld_in[b_slot_ff] = 1'b1;
            end
            if (scan_done) begin
               if (item_ff.op == OP_REM) begin
                  count_in          = count_ff - CW'(1);
                  ready_in[slot_ff] = 1'b0;
                  state_in          = S_DONE;
               end else begin
                  base_re    = 1'b1;
                  base_raddr = best_ff;
                  state_in   = S_BASE;
               end
            end
         end

         S_BASE: begin
            cur_we              = 1'b1;
            cur_waddr           = best_ff;
            cur_wdata           = base_val;
            cur_vld_in[best_ff] = 1'b1;
            res_in.chosen_slot  = to4(best_ff);
            res_in.chosen_valid = 1'b1;
            state_in            = S_DONE;
         end

         S_RR_A: begin
            ord_we    = 1'b1;
            ord_waddr = pos(head_ff, count_ff);
            ord_wdata = order_rd_ff;
            head_in   = pos(head_ff, CW'(1));
            state_in  = S_RR_B;
         end

         S_RR_B: begin
            ord_re    = 1'b1;
            ord_raddr = head_ff;
            state_in  = S_RR_C;
         end

         S_RR_C: begin
            res_in.chosen_slot  = to4(order_rd_ff);
            res_in.chosen_valid = 1'b1;
            state_in            = S_DONE;
         end

         S_READ: begin
            res_in.priority_out = cur_val;
            state_in            = S_DONE;
         end

         S_DONE: begin
            if (!out_vld_ff || rsp_tready) begin
               out_vld_in = 1'b1;
               out_in     = res_ff;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         ready_ff    <= '0;
         cur_vld_ff  <= '0;
         base_vld_ff <= '0;
         a_vld_ff    <= 1'b0;
         b_vld_ff    <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         ready_ff    <= ready_in;
         cur_vld_ff  <= cur_vld_in;
         base_vld_ff <= base_vld_in;
         a_vld_ff    <= a_vld_in;
         b_vld_ff    <= b_vld_in;
         out_vld_ff  <= out_vld_in;
      end
      item_ff      <= item_in;
      slot_ff      <= slot_in;
      iss_ff       <= iss_in;
      a_idx_ff     <= a_idx_in;
      b_slot_ff    <= b_slot_in;
      found_ff     <= found_in;
      best_vld_ff  <= best_vld_in;
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_mem[ord_waddr] <= ord_wdata;
      end
      if (ord_re) begin
         order_rd_ff <= order_mem[ord_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_waddr] <= cur_wdata;
      end
      if (cur_re) begin
         cur_rd_ff   <= cur_mem[cur_raddr];
         cur_rvld_ff <= cur_vld_ff[cur_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (base_we) begin
         base_mem[q_slot] <= q_item.prio;
      end
      if (base_re) begin
         base_rd_ff   <= base_mem[base_raddr];
         base_rvld_ff <= base_vld_ff[base_raddr];
      end
   end

   `PASU_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CW'(SLOTS), "ready count exceeds slot count")
   `PASU_ASSERT_ALWAYS(a_count_match, clock, reset, $countones(ready_ff) == 32'(count_ff), "ready flags disagree with count")
   `PASU_ASSERT_ALWAYS(a_head_range, clock, reset, 32'(head_ff) < SLOTS, "head position out of range")
   `PASU_ASSERT_NEXT(a_pop_leaves_idle, clock, reset, q_pop, state_ff != S_IDLE, "item popped but sequencer stayed idle")

endmodule

`default_nettype wire

// ===== design/priority_aging_scheduler_unit.sv =====
// Priority aging scheduler.
// Request channel req_*: one item carries func, task_slot and new_priority.
// Response channel rsp_*: exactly one item per request, in request order,
// with chosen_slot, chosen_valid, priority_out and status.
// csr_wen/csr_wdata write use_priority (0 round robin, 1 priority with aging);
// write it only while no request is in flight.
// Remove and priority schedule walk the whole ready list in order; the list walk
// reads one list entry per cycle from the order memory. One item is executed at
// a time: the back end takes the next queued item only once the response of the
// last one has been handed to the output register.
// A 2-deep queue in front keeps accepting while the back end works or a
// response is stalled; req_tready drops when the queue is full.
// Reset (synchronous) empties the list, clears all priorities to 0 and
// selects round robin. When rsp_tready is low the response holds.
// ----------------------------------------------------------------------------
// priority_aging_scheduler_unit
// Top level: configuration register, request front end, execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_aging_scheduler_unit import pasu_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wen,
   input  wire logic                  csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // func[2:0], task_slot[6:3], new_priority[12:7], zero [15:13]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // chosen_slot[3:0], chosen_valid[4], priority_out[10:5], status[13:11], zero [15:14]
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   logic          use_priority_ff;
   logic          q_valid;
   item_type      q_item;
   logic [SW-1:0] q_slot;
   logic          q_pop;
   rsp_type       rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_priority_ff <= 1'b0;
      end else if (csr_wen) begin
         use_priority_ff <= csr_wdata;
      end
   end

   pasu_front #(
      .SLOTS (SLOTS),
      .SW    (SW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_slot     (q_slot),
      .q_pop      (q_pop)
   );

   pasu_back #(
      .SLOTS (SLOTS),
      .SW    (SW),
      .CW    (CW)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .use_priority (use_priority_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_slot       (q_slot),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_data     (rsp_data)
   );

   assign rsp_tdata = {2'b00, rsp_data.status, rsp_data.priority_out,
                       rsp_data.chosen_valid, rsp_data.chosen_slot};

endmodule

`default_nettype wire
